// File: rtl/aesr_pkg.sv
`default_nettype none

package aesr_pkg;

   // Reduction constant of the AES field polynomial x^8 + x^4 + x^3 + x + 1.
   localparam logic [7:0] GF_POLY = 8'h1B;

   localparam int unsigned BLOCK_BYTES = 16;
   localparam int unsigned BLOCK_BITS  = 8 * BLOCK_BYTES;
   localparam int unsigned HALF_BITS   = BLOCK_BITS / 2;

   typedef logic [7:0] byte_type;
   typedef logic [BLOCK_BITS-1:0] block_type;

   // Operands of one round as held in the input register.
   typedef struct packed {
      block_type state;
      block_type round_key;
      logic      final_round;
   } round_in_type;

   localparam byte_type SBOX [256] = '{
      8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
      8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
      8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
      8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
      8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
      8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
      8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
      8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
      8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
      8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
      8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
      8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
      8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
      8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
      8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
      8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
      8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
      8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
      8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
      8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
      8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
      8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
      8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
      8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
      8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
      8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
      8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
      8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
      8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
      8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
   };

   function automatic byte_type sbox(input byte_type value);
      return SBOX[value];
   endfunction

   // Multiplication by x in GF(2^8).
   function automatic byte_type gf_double(input byte_type value);
      return {value[6:0], 1'b0} ^ (value[7] ? GF_POLY : 8'h00);
   endfunction

endpackage

`default_nettype wire

// File: rtl/aesr_if.sv
`default_nettype none

interface aesr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] state_lo;
   logic [63:0] state_hi;
   logic [63:0] key_lo;
   logic [63:0] key_hi;
   logic        final_round;

   modport source (
      output valid, state_lo, state_hi, key_lo, key_hi, final_round,
      input  ready
   );
   modport sink (
      input  valid, state_lo, state_hi, key_lo, key_hi, final_round,
      output ready
   );
endinterface

interface aesr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_lo;
   logic [63:0] result_hi;

   modport source (
      output valid, result_lo, result_hi,
      input  ready
   );
   modport sink (
      input  valid, result_lo, result_hi,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/aesr_round.sv
`default_nettype none

// One AES encryption round: ShiftRows, SubBytes, optional MixColumns, AddRoundKey.
module aesr_round (
   input  wire aesr_pkg::round_in_type operands,
   output aesr_pkg::block_type         result
);

   aesr_pkg::byte_type st_b  [aesr_pkg::BLOCK_BYTES];
   aesr_pkg::byte_type key_b [aesr_pkg::BLOCK_BYTES];
   aesr_pkg::byte_type sub_b [aesr_pkg::BLOCK_BYTES];
   aesr_pkg::byte_type mix_b [aesr_pkg::BLOCK_BYTES];

   for (genvar k = 0; k < aesr_pkg::BLOCK_BYTES; k++) begin : g_bytes
      assign st_b[k]  = operands.state[8*k +: 8];
      assign key_b[k] = operands.round_key[8*k +: 8];
   end

   // Row r of column c takes row r of column c+r, then goes through the S-box.
   for (genvar c = 0; c < 4; c++) begin : g_col
      for (genvar r = 0; r < 4; r++) begin : g_row
         localparam int Dst = 4 * c + r;
         localparam int Src = 4 * ((c + r) % 4) + r;
         localparam int A1  = 4 * c + (r + 1) % 4;
         localparam int A2  = 4 * c + (r + 2) % 4;
         localparam int A3  = 4 * c + (r + 3) % 4;

         assign sub_b[Dst] = aesr_pkg::sbox(st_b[Src]);

         assign mix_b[Dst] = aesr_pkg::gf_double(sub_b[Dst])
                           ^ aesr_pkg::gf_double(sub_b[A1])
                           ^ sub_b[A1] ^ sub_b[A2] ^ sub_b[A3];

         assign result[8*Dst +: 8] =
            (operands.final_round ? sub_b[Dst] : mix_b[Dst]) ^ key_b[Dst];
      end
   end

endmodule

`default_nettype wire

// File: rtl/aes_encrypt_round.sv
// An accepted transaction passes through the input register, then the result
// register, before it is shown on rsp_chan. The two registers absorb stalls.
// Throughput: one transaction per cycle while rsp_chan is ready.
// Reset clears only the two stage valid bits; payload registers are not reset.
`default_nettype none

module aes_encrypt_round (
   input wire       clock,
   input wire       reset,
   aesr_req_if.sink   req_chan,
   aesr_rsp_if.source rsp_chan
);

   // The block is a two-stage pipeline. Stage one holds the operands of an
   // accepted transaction. The round itself is purely combinational logic
   // between stage one and stage two, so in every cycle where stage one is
   // full and stage two is ready, one transaction moves to the result register.

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   aesr_pkg::round_in_type s1_data_ff;
   aesr_pkg::round_in_type s1_data_in;

   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   aesr_pkg::block_type    s2_data_ff;
   aesr_pkg::block_type    s2_data_in;

   aesr_pkg::block_type    round_result;

   logic req_fire;
   logic s2_ready;
   logic s1_advance;

   // Stage two can take a new result when it is empty or its result leaves
   // this cycle. Stage one can take a transaction when it is empty or its
   // contents move on to stage two this cycle.
   assign s2_ready   = !s2_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && s2_ready;
   assign req_chan.ready = !s1_valid_ff || s2_ready;
   assign req_fire   = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_data_in = s1_data_ff;
      if (req_fire) begin
         s1_data_in.state       = {req_chan.state_hi, req_chan.state_lo};
         s1_data_in.round_key   = {req_chan.key_hi, req_chan.key_lo};
         s1_data_in.final_round = req_chan.final_round;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   aesr_round u_round (
      .operands (s1_data_ff),
      .result   (round_result)
   );

   // The result register loads whenever stage one advances; otherwise it
   // holds, and drops its valid bit once the result has been taken.
   always_comb begin
      s2_data_in  = s2_data_ff;
      s2_valid_in = s2_valid_ff;
      if (s1_advance) begin
         s2_data_in  = round_result;
         s2_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign rsp_chan.valid     = s2_valid_ff;
   assign rsp_chan.result_lo = s2_data_ff[aesr_pkg::HALF_BITS-1:0];
   assign rsp_chan.result_hi = s2_data_ff[aesr_pkg::BLOCK_BITS-1:aesr_pkg::HALF_BITS];

`ifndef SYNTHESIS
   // An accepted transaction always lands in the input register.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted transaction did not reach the input register");

   // A stage-one transaction that moves on always shows up as a result.
   a_advance_fills_s2: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_chan.valid)
      else $error("advanced transaction did not reach the result register");

   // Input is refused only when both stages are full.
   a_backpressure_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && s2_valid_ff))
      else $error("input refused while a stage was free");

   // Operands waiting behind a stalled result stay put.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> $stable(s1_data_ff))
      else $error("input register changed while stalled");
`endif

endmodule

`default_nettype wire
